/* design/distinct_value_counter_unit_macros.svh */
// Assertion macros shared by the distinct value counter RTL.
// Each macro expects a clock named clk and an active-high reset named rst in scope.
`ifndef DISTINCT_VALUE_COUNTER_UNIT_MACROS_SVH
`define DISTINCT_VALUE_COUNTER_UNIT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define DVC_ASSERT_IMPLY(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define DVC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* design/dvc_pkg.sv */
// Shared types and constants for the distinct value counter.
// No dependencies; every design module imports this package.
package dvc_pkg;

  localparam int TABLE_DEPTH = 64;
  localparam int ADDR_W      = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
  localparam int VALUE_W     = 16;
  localparam int COUNT_W     = 32;

  typedef enum logic [1:0] {
    OP_ADD   = 2'd0,
    OP_READ  = 2'd1,
    OP_CLEAR = 2'd2
  } op_t;

  typedef enum logic [2:0] {
    ST_MATCHED = 3'd0,
    ST_NEW     = 3'd1,
    ST_FULL    = 3'd2,
    ST_SORTED  = 3'd3,
    ST_EMPTY   = 3'd4,
    ST_CLEARED = 3'd5
  } status_t;

  typedef struct packed {
    logic [VALUE_W-1:0] value;
    logic [COUNT_W-1:0] count;
  } entry_t;

  // Window for the sorted walk: the key emitted last and the best candidate so far.
  typedef struct packed {
    logic               have_lower;
    logic [VALUE_W-1:0] lower_key;
    logic               best_found;
    logic [VALUE_W-1:0] best_key;
  } bounds_t;

  typedef struct packed {
    logic               equal;
    logic               in_window;
    logic [VALUE_W-1:0] cand_key;
  } cmp_res_t;

endpackage

/* design/distinct_value_counter_unit.sv */
// Distinct value counter: add scans the n stored entries in order, one per cycle, and stops
// at the first match. Readout does one selection pass over all n entries per emitted entry;
// clear and empty readout answer straight from idle.
// busy stays high until the final result is driven, so the next item can start while that
// result is driven; results cannot be stalled. Synchronous reset empties the table and clears
// value_signed; entry contents are left as they are and are never read before being written.
module distinct_value_counter_unit (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  output logic                        busy,
  input  logic [1:0]                  operation,
  input  logic [dvc_pkg::VALUE_W-1:0] value,
  input  logic                        cfg_write,
  input  logic                        cfg_data,
  output logic                        result_strobe,
  output logic [dvc_pkg::VALUE_W-1:0] entry_value,
  output logic [dvc_pkg::COUNT_W-1:0] entry_count,
  output logic [2:0]                  status,
  output logic                        last
);
  import dvc_pkg::*;
  `include "distinct_value_counter_unit_macros.svh"

  typedef enum logic [1:0] {
    S_IDLE,
    S_ADD,
    S_READ
  } state_t;

  state_t             state;
  logic [CNT_W-1:0]   used;
  logic               value_signed;
  logic [VALUE_W-1:0] probe;
  logic [CNT_W-1:0]   rd_idx;
  logic               chk_valid;
  logic [ADDR_W-1:0]  chk_idx;
  logic [CNT_W-1:0]   emitted;
  bounds_t            bounds;
  logic [VALUE_W-1:0] best_value;
  logic [COUNT_W-1:0] best_count;

  entry_t             rd_data;
  entry_t             mem_wdata;
  logic               mem_we;
  logic [ADDR_W-1:0]  mem_waddr;
  cmp_res_t           cmp;
  logic               issue;
  logic               scan_done;
  logic [COUNT_W-1:0] count_inc;
  logic [CNT_W-1:0]   emitted_inc;

  dvc_table u_table (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (rd_idx[ADDR_W-1:0]),
    .rdata (rd_data)
  );

  dvc_cmp u_cmp (
    .cand         (rd_data.value),
    .probe        (probe),
    .value_signed (value_signed),
    .bounds       (bounds),
    .res          (cmp)
  );

  assign busy        = (state != S_IDLE);
  assign issue       = (rd_idx < used);
  assign scan_done   = (rd_idx == used) && !chk_valid;
  assign count_inc   = (rd_data.count == '1) ? rd_data.count : rd_data.count + 1'b1;
  assign emitted_inc = emitted + 1'b1;

  // Table writes: count update on a match, or an append at the end of a missed search when the table is not full.
  always_comb begin
    mem_we          = 1'b0;
    mem_waddr       = chk_idx;
    mem_wdata.value = rd_data.value;
    mem_wdata.count = count_inc;
    if (state == S_ADD && chk_valid && cmp.equal) begin
      mem_we = 1'b1;
    end else if (state == S_ADD && scan_done && used != CNT_W'(TABLE_DEPTH)) begin
      mem_we          = 1'b1;
      mem_waddr       = used[ADDR_W-1:0];
      mem_wdata.value = probe;
      mem_wdata.count = COUNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state             <= S_IDLE;
      used              <= '0;
      value_signed      <= 1'b0;
      result_strobe     <= 1'b0;
      rd_idx            <= '0;
      chk_valid         <= 1'b0;
      emitted           <= '0;
      bounds.have_lower <= 1'b0;
      bounds.best_found <= 1'b0;
    end else begin
      if (cfg_write) begin
        value_signed <= cfg_data;
      end
      result_strobe <= 1'b0;

      // The read pipeline advances the same way for search and sort passes.
      if (state != S_IDLE) begin
        if (issue) begin
          rd_idx <= rd_idx + 1'b1;
        end
        chk_idx   <= rd_idx[ADDR_W-1:0];
        chk_valid <= issue;
      end

      case (state)
        S_IDLE: begin
          if (start) begin
            case (op_t'(operation))
              OP_ADD: begin
                probe     <= value;
                rd_idx    <= '0;
                chk_valid <= 1'b0;
                state     <= S_ADD;
              end
              OP_READ: begin
                if (used == '0) begin
                  result_strobe <= 1'b1;
                  entry_value   <= '0;
                  entry_count   <= '0;
                  status        <= ST_EMPTY;
                  last          <= 1'b1;
                end else begin
                  rd_idx            <= '0;
                  chk_valid         <= 1'b0;
                  emitted           <= '0;
                  bounds.have_lower <= 1'b0;
                  bounds.best_found <= 1'b0;
                  state             <= S_READ;
                end
              end
              OP_CLEAR: begin
                used          <= '0;
                result_strobe <= 1'b1;
                entry_value   <= '0;
                entry_count   <= '0;
                status        <= ST_CLEARED;
                last          <= 1'b1;
              end
              default: begin
              end
            endcase
          end
        end
        S_ADD: begin
          if (chk_valid && cmp.equal) begin
            result_strobe <= 1'b1;
            entry_value   <= probe;
            entry_count   <= count_inc;
            status        <= ST_MATCHED;
            last          <= 1'b1;
            state         <= S_IDLE;
          end else if (scan_done) begin
            result_strobe <= 1'b1;
            entry_value   <= probe;
            last          <= 1'b1;
            state         <= S_IDLE;
            if (used == CNT_W'(TABLE_DEPTH)) begin
              entry_count <= '0;
              status      <= ST_FULL;
            end else begin
              entry_count <= COUNT_W'(1);
              status      <= ST_NEW;
              used        <= used + 1'b1;
            end
          end
        end
        S_READ: begin
          if (chk_valid && cmp.in_window) begin
            bounds.best_found <= 1'b1;
            bounds.best_key   <= cmp.cand_key;
            best_value        <= rd_data.value;
            best_count        <= rd_data.count;
          end else if (scan_done) begin
            // Emit the smallest key above the previous one, then start the next pass unless this was the last entry.
            result_strobe     <= 1'b1;
            entry_value       <= best_value;
            entry_count       <= best_count;
            status            <= ST_SORTED;
            last              <= (emitted_inc == used);
            bounds.have_lower <= 1'b1;
            bounds.lower_key  <= bounds.best_key;
            bounds.best_found <= 1'b0;
            emitted           <= emitted_inc;
            rd_idx            <= '0;
            if (emitted_inc == used) begin
              state <= S_IDLE;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  `DVC_ASSERT_NEXT(a_add_goes_busy, start && !busy && operation == OP_ADD, busy,
    "add transfer did not start a search")
  `DVC_ASSERT_IMPLY(a_last_ends_item, result_strobe && last, !busy,
    "final result driven while the block is still busy")
  `DVC_ASSERT_IMPLY(a_sorted_nonempty, result_strobe && status == ST_SORTED, used != '0,
    "sorted record emitted from an empty table")
  `DVC_ASSERT_IMPLY(a_used_bound, 1'b1, used <= CNT_W'(TABLE_DEPTH),
    "entry count exceeds the table depth")

endmodule

/* design/dvc_table.sv */
// Entry store of the distinct value counter: one write port, one registered read port.
// Depends on dvc_pkg for the entry type and address width.
module dvc_table (
  input  logic                       clk,
  input  logic                       we,
  input  logic [dvc_pkg::ADDR_W-1:0] waddr,
  input  dvc_pkg::entry_t            wdata,
  input  logic [dvc_pkg::ADDR_W-1:0] raddr,
  output dvc_pkg::entry_t            rdata
);
  import dvc_pkg::*;

  entry_t mem [TABLE_DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

/* design/dvc_cmp.sv */
// Shared compare unit: equality against the add probe and the sort window test.
// Depends on dvc_pkg for the bounds and result structs.
module dvc_cmp (
  input  logic [dvc_pkg::VALUE_W-1:0] cand,
  input  logic [dvc_pkg::VALUE_W-1:0] probe,
  input  logic                        value_signed,
  input  dvc_pkg::bounds_t            bounds,
  output dvc_pkg::cmp_res_t           res
);
  import dvc_pkg::*;

  logic [VALUE_W-1:0] key;

  // Flipping the sign bit maps two's complement order onto unsigned order.
  assign key = {cand[VALUE_W-1] ^ value_signed, cand[VALUE_W-2:0]};

  always_comb begin
    res.equal     = (cand == probe);
    res.cand_key  = key;
    res.in_window = (!bounds.have_lower || (key > bounds.lower_key)) &&
                    (!bounds.best_found || (key < bounds.best_key));
  end

endmodule
